/* rtl/sqltl_pkg.sv */
// Shared types, token codes and lookup functions for the SQL token lexer.
`default_nettype none

package sqltl_pkg;

    // Default widths of the internal counters
    localparam int OFFSET_BITS_DEF = 32;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int LINE_BITS_DEF   = 16;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Token kinds
    localparam logic [5:0] K_IDENT  = 6'd0;
    localparam logic [5:0] K_NUMBER = 6'd1;
    localparam logic [5:0] K_KEY0   = 6'd2;
    localparam logic [5:0] K_STAR   = 6'd21;
    localparam logic [5:0] K_COMMA  = 6'd22;
    localparam logic [5:0] K_LPAREN = 6'd23;
    localparam logic [5:0] K_RPAREN = 6'd24;
    localparam logic [5:0] K_SEMI   = 6'd25;
    localparam logic [5:0] K_QUOTE  = 6'd26;
    localparam logic [5:0] K_EQ     = 6'd27;
    localparam logic [5:0] K_GT     = 6'd28;
    localparam logic [5:0] K_LT     = 6'd29;
    localparam logic [5:0] K_GE     = 6'd30;
    localparam logic [5:0] K_LE     = 6'd31;
    localparam logic [5:0] K_NE     = 6'd32;
    localparam logic [5:0] K_BAD    = 6'd33;
    localparam logic [5:0] K_EOF    = 6'd34;

    // Characters with special meaning
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    // Keywords, packed right-justified like the identifier window
    localparam int NUM_KW = 19;
    localparam logic [63:0] KW_WORDS [NUM_KW] = '{
        64'("select"), 64'("from"), 64'("as"), 64'("create"), 64'("table"),
        64'("drop"), 64'("distinct"), 64'("top"), 64'("percent"),
        64'("where"), 64'("and"), 64'("or"), 64'("not"), 64'("is"),
        64'("null"), 64'("insert"), 64'("into"), 64'("values"),
        64'("delete")
    };

    // One result token as it leaves the block
    typedef struct packed {
        logic [15:0] line;
        logic [15:0] length;
        logic [31:0] start;
        logic [5:0]  kind;
    } t_token;

    // Up to two tokens caused by one input transfer
    typedef struct packed {
        logic   two;
        t_token tok1;
        t_token tok0;
    } t_entry;

    // Parallel compare of the identifier window against all keywords
    function automatic logic [5:0] kw_lookup(input logic [63:0] window);
        logic [5:0] kind;
        kind = K_IDENT;
        for (int i = 0; i < NUM_KW; i++) begin
            if (KW_WORDS[i] == window) begin
                kind = K_KEY0 + 6'(i);
            end
        end
        return kind;
    endfunction

    // Kind of a byte that stands alone as a token
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] kind;
        case (c)
            CH_STAR:   kind = K_STAR;
            CH_COMMA:  kind = K_COMMA;
            CH_LPAREN: kind = K_LPAREN;
            CH_RPAREN: kind = K_RPAREN;
            CH_SEMI:   kind = K_SEMI;
            CH_QUOTE:  kind = K_QUOTE;
            CH_EQ:     kind = K_EQ;
            CH_GT:     kind = K_GT;
            CH_LT:     kind = K_LT;
            default:   kind = K_BAD;
        endcase
        return kind;
    endfunction

endpackage

`default_nettype wire

/* rtl/sqltl_front.sv */
// Front part: scans one byte per transfer, tracks the pending token, builds result entries.
`default_nettype none

module sqltl_front import sqltl_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_accept,   // input transfer this cycle
    input  wire logic [7:0] i_char,
    input  wire logic   i_end,
    output logic        o_push,     // entry produced by this transfer
    output t_entry      o_entry
);

    typedef enum logic [1:0] {
        PC_NONE,
        PC_IDENT,
        PC_NUMBER,
        PC_HELD
    } t_pclass;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

    t_pclass                 r_class,  n_class;
    logic [OFFSET_BITS-1:0]  r_start,  n_start;
    logic [LENGTH_BITS-1:0]  r_len,    n_len;
    logic [63:0]             r_window, n_window;
    logic [7:0]              r_held,   n_held;
    logic [OFFSET_BITS-1:0]  r_offset, n_offset;
    logic [LINE_BITS-1:0]    r_line,   n_line;

    logic [7:0]  c;
    logic        is_alpha, is_digit, is_space, pair;
    logic        have_flush, have_new;
    t_token      flush_tok, new_tok;
    logic [5:0]  pair_kind;

    // Token stamped with the line at emission
    function automatic t_token mk_tok(input logic [5:0] kind,
                                      input logic [OFFSET_BITS-1:0] start,
                                      input logic [LENGTH_BITS-1:0] len,
                                      input logic [LINE_BITS-1:0] line);
        t_token t;
        t.kind   = kind;
        t.start  = 32'(start);
        t.length = 16'(len);
        t.line   = 16'(line);
        return t;
    endfunction

    // Byte classification after case folding
    always_comb begin
        c = i_char;
        if (i_char >= CH_UC_A && i_char <= CH_UC_Z) begin
            c = i_char + CASE_GAP;
        end
        is_alpha = (c >= CH_LC_A) && (c <= CH_LC_Z);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        pair_kind = K_GE;
        if (r_held == CH_LT) begin
            pair_kind = (c == CH_GT) ? K_NE : K_LE;
        end
        // the byte beside an end marker carries no meaning
        pair = !i_end && (r_class == PC_HELD) &&
               (((r_held == CH_GT) && (c == CH_EQ)) ||
                ((r_held == CH_LT) && ((c == CH_EQ) || (c == CH_GT))));
    end

    // Token that the pending state would close now
    always_comb begin
        case (r_class)
            PC_IDENT: begin
                flush_tok = mk_tok((r_len > LENGTH_BITS'(8)) ? K_IDENT : kw_lookup(r_window),
                                   r_start, r_len, r_line);
            end
            PC_NUMBER: flush_tok = mk_tok(K_NUMBER, r_start, r_len, r_line);
            PC_HELD: begin
                flush_tok = mk_tok((r_held == CH_LT) ? K_LT : K_GT, r_start,
                                   LENGTH_BITS'(1), r_line);
            end
            default: flush_tok = mk_tok(K_IDENT, r_start, r_len, r_line);
        endcase
    end

    // Next state and the tokens of this byte
    always_comb begin
        n_class    = r_class;
        n_start    = r_start;
        n_len      = r_len;
        n_window   = r_window;
        n_held     = r_held;
        n_offset   = r_offset;
        n_line     = r_line;
        have_flush = 1'b0;
        have_new   = 1'b0;
        new_tok    = mk_tok(K_BAD, r_offset, '0, r_line);

        if (i_end) begin
            // close the source: flush, EOF, back to reset values
            have_flush = (r_class != PC_NONE);
            have_new   = 1'b1;
            new_tok    = mk_tok(K_EOF, r_offset, '0, r_line);
            n_class    = PC_NONE;
            n_start    = '0;
            n_len      = '0;
            n_window   = '0;
            n_held     = '0;
            n_offset   = '0;
            n_line     = LINE_BITS'(1);
        end else begin
            n_offset = r_offset + OFFSET_BITS'(1);
            if (pair) begin
                have_flush = 1'b1;
                n_class    = PC_NONE;
            end else if ((r_class == PC_IDENT) && (is_alpha || (c == CH_USCORE))) begin
                n_len    = (r_len == LEN_MAX) ? r_len : r_len + LENGTH_BITS'(1);
                n_window = {r_window[55:0], c};
            end else if ((r_class == PC_NUMBER) && is_digit) begin
                n_len = (r_len == LEN_MAX) ? r_len : r_len + LENGTH_BITS'(1);
            end else begin
                have_flush = (r_class != PC_NONE);
                n_class    = PC_NONE;
                if (is_space) begin
                    if ((c == CH_NL) && (r_line != LINE_MAX)) begin
                        n_line = r_line + LINE_BITS'(1);
                    end
                end else if (is_alpha || is_digit || (c == CH_LT) || (c == CH_GT)) begin
                    n_class  = is_alpha ? PC_IDENT : (is_digit ? PC_NUMBER : PC_HELD);
                    n_start  = r_offset;
                    n_len    = LENGTH_BITS'(1);
                    n_window = 64'(c);
                    n_held   = c;
                end else begin
                    have_new = 1'b1;
                    new_tok  = mk_tok(single_kind(c), r_offset,
                                      (single_kind(c) == K_BAD) ? '0 : LENGTH_BITS'(1),
                                      r_line);
                end
            end
        end
    end

    // Pack the entry: flushed token first
    always_comb begin
        o_push        = i_accept && (have_flush || have_new);
        o_entry.two   = have_flush && have_new;
        o_entry.tok0  = have_flush ? (pair ? mk_tok(pair_kind, r_start, LENGTH_BITS'(2), r_line)
                                           : flush_tok)
                                   : new_tok;
        o_entry.tok1  = new_tok;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class  <= PC_NONE;
            r_start  <= '0;
            r_len    <= '0;
            r_window <= '0;
            r_held   <= '0;
            r_offset <= '0;
            r_line   <= LINE_BITS'(1);
        end else if (i_accept) begin
            r_class  <= n_class;
            r_start  <= n_start;
            r_len    <= n_len;
            r_window <= n_window;
            r_held   <= n_held;
            r_offset <= n_offset;
            r_line   <= n_line;
        end
    end

endmodule

`default_nettype wire

/* rtl/sqltl_queue.sv */
// Short entry queue between the front and the back.
`default_nettype none

module sqltl_queue import sqltl_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_valid,
    output t_entry      o_head
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_entry                r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0]   r_count;
    logic                  do_pop;

    assign o_full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_BITS'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/sqltl_back.sv */
// Back part: splits queue entries into single tokens behind an output register.
`default_nettype none

module sqltl_back import sqltl_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_entry i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_token      o_tok,
    output logic        o_last
);

    logic   r_sel;
    logic   r_valid;
    t_token r_tok;
    logic   r_last;
    logic   load, sel_last;

    assign load     = i_valid && (!r_valid || i_ready);
    assign sel_last = r_sel || !i_head.two;
    assign o_pop    = load && sel_last;
    assign o_valid  = r_valid;
    assign o_tok    = r_tok;
    assign o_last   = r_last;

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= r_sel ? i_head.tok1 : i_head.tok0;
            r_last <= sel_last;
        end
    end

    // Valid flag and position within the entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= !sel_last;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/sql_token_lexer.sv */
// Top level of the streaming SQL tokenizer.
//
//  Channel   Dir  tdata                                    tlast
//  s_axis    in   [7:0] char_byte                          end_marker
//  m_axis    out  [5:0] kind [37:6] start [53:38] length   last_of_run
//                 [69:54] line, [71:70] zero
//
// One byte is taken per cycle while the queue is not full; the front scans it
// in the cycle of its transfer. A byte that closes one token and makes another
// yields two tokens, so the output side sets the rate, through a 4-entry queue:
// one token per cycle while m_axis_tready is high, from the output register.
// Reset is synchronous, active low; it returns the scan to offset 0, line 1.
// Either side may stall; the queue and the output register keep them apart.
`default_nettype none

module sql_token_lexer import sqltl_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] char_byte
    input  wire logic        s_axis_tlast,    // end_marker
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,    // kind, start, length, line, pad
    output logic             m_axis_tlast     // last_of_run
);

    logic   accept;
    logic   push, full, q_valid, pop;
    t_entry push_entry, head;
    t_token out_tok;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sqltl_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (s_axis_tdata),
        .i_end    (s_axis_tlast),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    sqltl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head)
    );

    sqltl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tok   (out_tok),
        .o_last  (m_axis_tlast)
    );

    // Token fields packed from the lowest bit up
    assign m_axis_tdata = {2'b00, out_tok};

endmodule

`default_nettype wire

/* dv/sql_token_lexer_tb.sv */
// Self-checking testbench for the streaming SQL token lexer.
`timescale 1ns / 1ps

module sql_token_lexer_tb;
    import sqltl_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1500;
    localparam int MAX_REPORTS  = 50;
    localparam int KW_DISTINCT  = 6;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    // Kind of token the lexer has not finished yet
    typedef enum logic [1:0] {
        PEND_NONE, PEND_IDENT, PEND_NUMBER, PEND_HELD
    } t_pend;

    // One expected token
    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [15:0] length;
        logic [15:0] line;
        logic        last;
    } t_exp_tok;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] char_byte
    logic        s_axis_tlast = 1'b0;  // end_marker
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;         // [5:0] kind, [37:6] start, [53:38] length,
                                       // [69:54] line, [71:70] zero
    logic        m_axis_tlast;         // last_of_run

    sql_token_lexer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Lexer state mirrored by the predictor
    t_pend       lx_cls;
    logic [31:0] lx_start;
    logic [15:0] lx_len;
    logic [63:0] lx_window;
    logic [7:0]  lx_held;
    logic [31:0] lx_off;
    logic [15:0] lx_line;

    t_exp_tok    pending_tokens[$];   // expected tokens, oldest first
    t_exp_tok    step_tokens[$];      // tokens caused by the current transfer

    int          errors = 0;
    int          bytes_sent = 0;
    int          ends_sent = 0;
    int          tokens_checked = 0;
    int unsigned cycles = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int unsigned rx_hold_req = 0;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic logic [63:0] kw_word(input int idx);
        case (idx)
            0:  return "select";
            1:  return "from";
            2:  return "as";
            3:  return "create";
            4:  return "table";
            5:  return "drop";
            6:  return "distinct";
            7:  return "top";
            8:  return "percent";
            9:  return "where";
            10: return "and";
            11: return "or";
            12: return "not";
            13: return "is";
            14: return "null";
            15: return "insert";
            16: return "into";
            17: return "values";
            default: return "delete";
        endcase
    endfunction

    function automatic void lex_reset();
        lx_cls    = PEND_NONE;
        lx_start  = '0;
        lx_len    = '0;
        lx_window = '0;
        lx_held   = '0;
        lx_off    = '0;
        lx_line   = 16'd1;
    endfunction

    function automatic void lex_emit(input logic [5:0] kind, input logic [31:0] start,
                                     input logic [15:0] len);
        t_exp_tok t;
        t.kind   = kind;
        t.start  = start;
        t.length = len;
        t.line   = lx_line;
        t.last   = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [5:0] symbol_kind(input logic [7:0] c);
        case (c)
            CH_STAR:   return K_STAR;
            CH_COMMA:  return K_COMMA;
            CH_LPAREN: return K_LPAREN;
            CH_RPAREN: return K_RPAREN;
            CH_SEMI:   return K_SEMI;
            CH_QUOTE:  return K_QUOTE;
            CH_EQ:     return K_EQ;
            CH_GT:     return K_GT;
            CH_LT:     return K_LT;
            default:   return K_BAD;
        endcase
    endfunction

    function automatic logic [5:0] ident_kind();
        logic [5:0] kind;
        kind = K_IDENT;
        if (lx_len <= 16'd8) begin
            for (int i = 0; i < NUM_KW; i++) begin
                if (kw_word(i) == lx_window) kind = K_KEY0 + 6'(i);
            end
        end
        return kind;
    endfunction

    function automatic void lex_flush();
        logic [5:0] k;
        case (lx_cls)
            PEND_IDENT:  lex_emit(ident_kind(), lx_start, lx_len);
            PEND_NUMBER: lex_emit(K_NUMBER, lx_start, lx_len);
            PEND_HELD: begin
                k = symbol_kind(lx_held);
                lex_emit(k, lx_start, (k == K_BAD) ? 16'd0 : 16'd1);
            end
            default: ;
        endcase
        lx_cls = PEND_NONE;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return c >= CH_LC_A && c <= CH_LC_Z;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void lex_start(input t_pend cls, input logic [7:0] c);
        lx_cls    = cls;
        lx_start  = lx_off;
        lx_len    = 16'd1;
        lx_window = {56'd0, c};
        lx_held   = c;
    endfunction

    function automatic void lex_byte(input logic [7:0] c);
        logic [5:0] pair;
        // a held < or > either pairs with this byte or goes out alone
        if (lx_cls == PEND_HELD) begin
            pair = K_BAD;
            if (lx_held == CH_GT && c == CH_EQ) pair = K_GE;
            else if (lx_held == CH_LT && c == CH_EQ) pair = K_LE;
            else if (lx_held == CH_LT && c == CH_GT) pair = K_NE;
            if (pair != K_BAD) begin
                lex_emit(pair, lx_start, 16'd2);
                lx_cls = PEND_NONE;
                return;
            end
            lex_flush();
        end
        // extend a pending identifier or number
        if (lx_cls == PEND_IDENT) begin
            if (is_letter(c) || c == CH_USCORE) begin
                lx_len    = sat_inc(lx_len);
                lx_window = {lx_window[55:0], c};
                return;
            end
            lex_flush();
        end else if (lx_cls == PEND_NUMBER) begin
            if (is_digit(c)) begin
                lx_len = sat_inc(lx_len);
                return;
            end
            lex_flush();
        end
        // the byte starts something new
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            if (c == CH_NL && lx_line != 16'hFFFF) lx_line = lx_line + 16'd1;
        end else if (is_letter(c)) begin
            lex_start(PEND_IDENT, c);
        end else if (is_digit(c)) begin
            lex_start(PEND_NUMBER, c);
        end else if (c == CH_LT || c == CH_GT) begin
            lex_start(PEND_HELD, c);
        end else if (symbol_kind(c) != K_BAD) begin
            lex_emit(symbol_kind(c), lx_off, 16'd1);
        end else begin
            lex_emit(K_BAD, lx_off, 16'd0);
        end
    endfunction

    // Expected tokens for one accepted transfer
    function automatic void lex_predict(input logic [7:0] b, input logic endm);
        logic [7:0] c;
        step_tokens.delete();
        if (endm) begin
            lex_flush();
            lex_emit(K_EOF, lx_off, 16'd0);
            lex_reset();
        end else begin
            c = (b >= CH_UC_A && b <= CH_UC_Z) ? b + CASE_GAP : b;
            lex_byte(c);
            lx_off = lx_off + 32'd1;
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
    endfunction

    initial lex_reset();

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    task automatic send_item(input logic [7:0] b, input logic endm);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= endm;
        do @(posedge i_clk); while (!s_axis_tready);
        lex_predict(b, endm);
        if (endm) ends_sent++;
        else bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    task automatic send_letter(input logic [7:0] lc);
        send_item($urandom_range(0, 1) ? lc - CASE_GAP : lc, 1'b0);
    endtask

    // keyword text, optionally without its last few letters
    task automatic send_word(input logic [63:0] w, input int skip_low);
        for (int i = 7; i >= skip_low; i--) begin
            if (w[i*8 +: 8] != 8'h00) send_letter(w[i*8 +: 8]);
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Receiver side: random stalls, plus a long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        int unsigned n;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req != 0) begin
                n = rx_hold_req;
                rx_hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_exp_tok want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_tokens.size() == 0) begin
                errors++;
                $display("%0t: unexpected token, expected none, actual kind %0d start %0d",
                         $time, m_axis_tdata[5:0], m_axis_tdata[37:6]);
            end else begin
                want = pending_tokens.pop_front();
                tokens_checked++;
                check_field("kind",   32'(want.kind),   32'(m_axis_tdata[5:0]));
                check_field("start",  want.start,       m_axis_tdata[37:6]);
                check_field("length", 32'(want.length), 32'(m_axis_tdata[53:38]));
                check_field("line",   32'(want.line),   32'(m_axis_tdata[69:54]));
                check_field("last",   32'(want.last),   32'(m_axis_tlast));
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Edge cases: empty source, newline ending a token, bytes that cannot
    // start a token, unpaired and paired < >, long identifier ending in a
    // keyword, restart after the end marker
    task automatic test_directed();
        send_item(8'h00, 1'b1);
        send_text("SeL\n_");
        send_item(8'h00, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("<,>=xdistinct9<");
        send_item(8'hFF, 1'b1);
        send_text("Z");
        send_item(8'h00, 1'b1);
        wait_drain();
    endtask

    // Receiver holds off while the sender keeps offering two-token bytes
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_hold_req = 200;
        for (int i = 0; i < 24; i++) send_text("a,");
        send_text("from<");
        send_item(8'h00, 1'b1);
        wait_drain();
        tx_idle_on = 1'b1;
    endtask

    function automatic logic [7:0] space_char();
        case ($urandom_range(0, 7))
            0: return CH_TAB;
            1: return CH_VT;
            2: return CH_FF;
            3: return CH_CR;
            4, 5: return CH_NL;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] symbol_char();
        case ($urandom_range(0, 8))
            0: return CH_STAR;
            1: return CH_COMMA;
            2: return CH_LPAREN;
            3: return CH_RPAREN;
            4: return CH_SEMI;
            5: return CH_QUOTE;
            6: return CH_EQ;
            7: return CH_GT;
            default: return CH_LT;
        endcase
    endfunction

    // SQL-like sources with random content, some noise and stray end markers
    task automatic test_random_sources();
        int goal;
        int r;
        int n;
        logic [63:0] w;
        goal = bytes_sent + ends_sent + RANDOM_ITEMS;
        while (bytes_sent + ends_sent < goal) begin
            if (bytes_sent + ends_sent > goal - 300) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            r = $urandom_range(0, 99);
            if (r < 25) begin
                send_word(kw_word($urandom_range(0, NUM_KW - 1)), 0);
            end else if (r < 40) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_letter(CH_LC_A + 8'($urandom_range(0, 25)));
                    send_word(kw_word(KW_DISTINCT), 0);
                end else begin
                    n = $urandom_range(1, 12);
                    send_letter(CH_LC_A + 8'($urandom_range(0, 25)));
                    for (int i = 1; i < n; i++) begin
                        if ($urandom_range(0, 5) == 0) send_item(CH_USCORE, 1'b0);
                        else send_letter(CH_LC_A + 8'($urandom_range(0, 25)));
                    end
                end
            end else if (r < 52) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) send_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            end else if (r < 67) begin
                send_item(symbol_char(), 1'b0);
            end else if (r < 75) begin
                case ($urandom_range(0, 2))
                    0: send_text(">=");
                    1: send_text("<=");
                    default: send_text("<>");
                endcase
            end else if (r < 85) begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) send_item(space_char(), 1'b0);
            end else if (r < 92) begin
                send_item(8'($urandom_range(0, 255)), 1'b0);
            end else if (r < 96) begin
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                // near-misses of keywords
                w = kw_word($urandom_range(0, NUM_KW - 1));
                case ($urandom_range(0, 2))
                    0: send_word(w, 1);
                    1: begin
                        send_word(w, 0);
                        send_letter(CH_LC_A + 8'($urandom_range(0, 25)));
                    end
                    default: begin
                        send_word(w, 0);
                        send_item(CH_USCORE, 1'b0);
                    end
                endcase
            end
            if (r < 75 && $urandom_range(0, 1) == 0) send_item(space_char(), 1'b0);
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
        wait_drain();
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random_sources();

        errors += pending_tokens.size();
        $display("Sent %0d source bytes and %0d end markers, checked %0d tokens",
                 bytes_sent, ends_sent, tokens_checked);
        $display("Runs included output hold-off, symbol pairs, keyword near-misses, random SQL");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
